>>> design/bscf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bscf_pkg
// Shared types, sizes and word helpers for the bit map block.
// ----------------------------------------------------------------------------
package bscf_pkg;

  localparam int MAX_BITS   = 1024;
  localparam int WORD_BITS  = 16;
  localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int POS_W      = 11;
  localparam int ADDR_W     = $clog2(WORD_COUNT);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int CNT_W      = $clog2(WORD_COUNT + 1);

  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_BITS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [BIT_W-1:0]     bidx_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TEST  = 2'd2,
    OP_FIND  = 2'd3
  } op_t;

  // Scan result for one word
  typedef struct packed {
    logic  hit;
    bidx_t idx;
  } hit_t;

  // Bits of a word that lie inside the capacity; only the last word is partial.
  function automatic word_t word_mask(input logic is_last, input bidx_t last_bit);
    word_t m;
    m = '1;
    if (is_last) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        m[i] = (BIT_W'(i) <= last_bit);
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

>>> design/bscf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bscf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bscf_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> design/bscf_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bscf_scan
// Mask one map word to the searched range and return its lowest set bit.
// ----------------------------------------------------------------------------
module bscf_scan (
  input  wire bscf_pkg::word_t word,
  input  wire logic            first,     // word holding the start position
  input  wire bscf_pkg::bidx_t start_bit,
  input  wire logic            is_last,   // last word inside the capacity
  input  wire bscf_pkg::bidx_t last_bit,
  output bscf_pkg::hit_t       res
);

  bscf_pkg::word_t keep;

  always_comb begin
    keep = word & bscf_pkg::word_mask(is_last, last_bit);
    for (int i = 0; i < bscf_pkg::WORD_BITS; i++) begin
      if (first && (bscf_pkg::BIT_W'(i) < start_bit)) begin
        keep[i] = 1'b0;
      end
    end
    res.hit = |keep;
    res.idx = '0;
    for (int i = bscf_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (keep[i]) begin
        res.idx = bscf_pkg::BIT_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

>>> design/bitmap_set_clear_find.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_set_clear_find
// Bit map with set, clear, test and find-first-set on 1-based positions.
// ----------------------------------------------------------------------------
// The map lives in a 64 x 16-bit RAM with a registered read port, plus one
// valid flop per word so that reset and a capacity write clear the whole map
// at once (a word never written since reads as zero). Set, clear, test and
// any request with a bad position pass through these steps between acceptance
// and the next acceptance: accept and read, execute (read-modify-write), hand
// off to the output register, which waits while that register is still full.
// Find walks the RAM one word per cycle from the word that holds the start
// position up to the last word in use, reading 1 to 64 words. The all-set flag
// comes from a counter of words that still hold a clear bit inside the
// capacity, updated on each write, so no scan is needed for it. A finished
// result waits in the output register while the next request is taken.
// Write the capacity only while no request is in flight.
// ----------------------------------------------------------------------------
module bitmap_set_clear_find (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [10:0] cfg_wr_data,   // capacity
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,      // [1:0] op, [12:2] position, [15:13] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata      // [0] bit_value, [11:1] found_position,
                                          // [12] position_error, [13] all_set,
                                          // [15:14] zero
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_PUSH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Request held across the walk
  bscf_pkg::op_t   op_r, op_nxt;
  logic            err_r, err_nxt;
  bscf_pkg::addr_t w_r, w_nxt;
  bscf_pkg::bidx_t b_r, b_nxt;
  logic            first_r, first_nxt;

  // Pending result
  logic            bv_r, bv_nxt;
  bscf_pkg::pos_t  found_r, found_nxt;

  // Map bookkeeping
  bscf_pkg::pos_t  cap_r;
  bscf_pkg::cnt_t  cnt_r, cnt_nxt;
  logic [bscf_pkg::WORD_COUNT-1:0] valid_r;
  logic            vq_r;

  // Output register
  logic            out_valid_r;
  logic [15:0]     out_data_r;

  // RAM ports
  logic            rd_en, wr_en;
  bscf_pkg::addr_t rd_addr;
  bscf_pkg::word_t rdata, wdata, cur_word;

  bscf_pkg::pos_t  used_bits, used_m1, in_pos, in_pm1;
  bscf_pkg::addr_t last_w;
  bscf_pkg::bidx_t last_b;
  bscf_pkg::word_t use_m;
  bscf_pkg::hit_t  scan_res;
  logic            is_last, old_full, new_full, in_acc, push;

  logic [bscf_pkg::POS_W-1:0] cfg_used;
  logic [bscf_pkg::POS_W:0]   cfg_words;

  // Saturate capacity to the map size
  assign used_bits = (cap_r > bscf_pkg::MAX_POS) ? bscf_pkg::MAX_POS : cap_r;
  assign used_m1   = used_bits - bscf_pkg::POS_W'(1);
  assign last_w    = used_m1[bscf_pkg::BIT_W +: bscf_pkg::ADDR_W];
  assign last_b    = used_m1[bscf_pkg::BIT_W-1:0];
  assign is_last   = (w_r == last_w);

  assign in_pos = in_tdata[12:2];
  assign in_pm1 = in_pos - bscf_pkg::POS_W'(1);

  assign cfg_used  = (cfg_wr_data > bscf_pkg::MAX_POS) ? bscf_pkg::MAX_POS : cfg_wr_data;
  assign cfg_words = ({1'b0, cfg_used} + (bscf_pkg::POS_W + 1)'(bscf_pkg::WORD_BITS - 1))
                     >> bscf_pkg::BIT_W;

  // Words never written since the last clear read as zero
  assign cur_word = vq_r ? rdata : '0;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign push      = (state_r == ST_PUSH) && (!out_valid_r || out_tready);

  assign use_m    = bscf_pkg::word_mask(is_last, last_b);
  assign old_full = ((cur_word & use_m) == use_m);

  bscf_ram #(
    .DEPTH (bscf_pkg::WORD_COUNT),
    .WIDTH (bscf_pkg::WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (w_r),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  bscf_scan u_scan (
    .word      (cur_word),
    .first     (first_r),
    .start_bit (b_r),
    .is_last   (is_last),
    .last_bit  (last_b),
    .res       (scan_res)
  );

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    err_nxt   = err_r;
    w_nxt     = w_r;
    b_nxt     = b_r;
    first_nxt = first_r;
    bv_nxt    = bv_r;
    found_nxt = found_r;
    cnt_nxt   = cnt_r;
    rd_en     = 1'b0;
    rd_addr   = w_r + bscf_pkg::ADDR_W'(1);
    wr_en     = 1'b0;
    wdata     = cur_word;
    new_full  = old_full;

    unique case (state_r)
      ST_IDLE: begin
        rd_addr = in_pm1[bscf_pkg::BIT_W +: bscf_pkg::ADDR_W];
        if (in_acc) begin
          // Latch the request and start the first word read
          rd_en     = 1'b1;
          op_nxt    = bscf_pkg::op_t'(in_tdata[1:0]);
          err_nxt   = (in_pos == '0) || (in_pos > used_bits);
          w_nxt     = in_pm1[bscf_pkg::BIT_W +: bscf_pkg::ADDR_W];
          b_nxt     = in_pm1[bscf_pkg::BIT_W-1:0];
          first_nxt = 1'b1;
          bv_nxt    = 1'b0;
          found_nxt = '0;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (err_r) begin
          state_nxt = ST_PUSH;
        end else begin
          case (op_r) inside
            bscf_pkg::OP_SET, bscf_pkg::OP_CLEAR: begin
              wdata[b_r] = (op_r == bscf_pkg::OP_SET);
              wr_en      = 1'b1;
              new_full   = ((wdata & use_m) == use_m);
              // Track words with a clear bit inside the capacity
              if (old_full && !new_full) begin
                cnt_nxt = cnt_r + bscf_pkg::CNT_W'(1);
              end else if (!old_full && new_full) begin
                cnt_nxt = cnt_r - bscf_pkg::CNT_W'(1);
              end
              state_nxt = ST_PUSH;
            end
            bscf_pkg::OP_TEST: begin
              bv_nxt    = cur_word[b_r];
              state_nxt = ST_PUSH;
            end
            default: begin
              first_nxt = 1'b0;
              if (scan_res.hit) begin
                found_nxt = bscf_pkg::POS_W'({w_r, scan_res.idx}) + bscf_pkg::POS_W'(1);
                state_nxt = ST_PUSH;
              end else if (is_last) begin
                state_nxt = ST_PUSH;
              end else begin
                // Advance to the next word
                rd_en = 1'b1;
                w_nxt = w_r + bscf_pkg::ADDR_W'(1);
              end
            end
          endcase
        end
      end
      ST_PUSH: begin
        if (push) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= bscf_pkg::MAX_POS;
      cnt_r       <= bscf_pkg::CNT_W'(bscf_pkg::WORD_COUNT);
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Capacity write clears the map; every word in use starts incomplete
      if (cfg_wr_en) begin
        cap_r   <= cfg_wr_data;
        cnt_r   <= bscf_pkg::CNT_W'(cfg_words);
        valid_r <= '0;
      end else begin
        cnt_r <= cnt_nxt;
        if (wr_en) begin
          valid_r[w_r] <= 1'b1;
        end
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    err_r   <= err_nxt;
    w_r     <= w_nxt;
    b_r     <= b_nxt;
    first_r <= first_nxt;
    bv_r    <= bv_nxt;
    found_r <= found_nxt;
    if (rd_en) begin
      vq_r <= valid_r[rd_addr];
    end
    if (push) begin
      out_data_r <= {2'b00, (cnt_r == '0), err_r, found_r, bv_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

>>> design/bscf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bscf_checker
// Port-level checks on the bit map block, bound to its top level.
// ----------------------------------------------------------------------------
module bscf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // One request in flight: no acceptance right after an acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is at work");

  // A bad position reports no bit and no found position
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12] |-> (out_tdata[11:0] == 12'd0))
    else $error("error result carries data");

  // Found position and tested bit never come together
  a_find_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[11:1] != 11'd0) |-> !out_tdata[0])
    else $error("find result carries a tested bit");

endmodule

bind bitmap_set_clear_find bscf_checker u_bscf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
